// ===== hw/rtl/dsdlb_pkg.sv =====
// Shared types and constants of the depth sorted draw list batcher.
`timescale 1ns / 1ps
package dsdlb_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 32;
  localparam int unsigned DEPTH_W        = 16;
  localparam int unsigned TEX_W          = 8;
  localparam int unsigned COUNT_W        = 16;
  localparam int unsigned HANDLE_W       = 16;
  localparam int unsigned OFFSET_W       = 22;
  localparam int unsigned STATUS_W       = 2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FLUSHED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  typedef struct packed {
    logic signed [DEPTH_W-1:0] depth;
    logic [TEX_W-1:0]          tex;
    logic [COUNT_W-1:0]        count;
    logic [HANDLE_W-1:0]       handle;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_CMP  = 2'd1,
    CMD_INS  = 2'd2,
    CMD_POP  = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    entry_t    item;
  } list_ctrl_t;

  typedef struct packed {
    logic             head_valid;
    entry_t           head;
    logic             next_valid;
    logic [TEX_W-1:0] next_tex;
    logic             full;
  } list_stat_t;

endpackage

// ===== hw/rtl/dsdlb_cell.sv =====
// One slot of a sorted draw list: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps
module dsdlb_cell
  import dsdlb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_i,
  input  list_ctrl_t ctrl_i,
  input  entry_t     left_i,
  input  logic       left_valid_i,
  input  entry_t     right_i,
  input  logic       right_valid_i,
  input  logic       shift_i,
  output logic       shift_o,
  output entry_t     ent_o,
  output logic       valid_o
);

  entry_t ent_q;
  logic   valid_q, valid_d;
  logic   hit_q, hit_d;
  logic   deeper, same_slot;

  assign deeper    = $signed(ctrl_i.item.depth) > $signed(ent_q.depth);
  assign same_slot = !head_i && (ctrl_i.item.depth == ent_q.depth)
                     && (ctrl_i.item.tex == ent_q.tex);
  assign hit_d     = valid_q ? (deeper || same_slot) : 1'b1;
  assign shift_o   = shift_i | hit_q;

  always_comb begin
    valid_d = valid_q;
    case (ctrl_i.cmd)
      CMD_INS: begin
        if (shift_i) begin
          valid_d = left_valid_i;
        end else if (hit_q) begin
          valid_d = 1'b1;
        end
      end
      CMD_POP: valid_d = right_valid_i;
      default: valid_d = valid_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.cmd == CMD_CMP) begin
        hit_q <= hit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CMD_INS: begin
        if (shift_i) begin
          ent_q <= left_i;
        end else if (hit_q) begin
          ent_q <= ctrl_i.item;
        end
      end
      CMD_POP: ent_q <= right_i;
      default: ent_q <= ent_q;
    endcase
  end

  assign ent_o   = ent_q;
  assign valid_o = valid_q;

endmodule

// ===== hw/rtl/dsdlb_list.sv =====
// Row of list cells forming one depth-sorted draw list.
`timescale 1ns / 1ps
module dsdlb_list
  import dsdlb_pkg::*;
#(
  parameter int unsigned DEPTH = LIST_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  list_ctrl_t ctrl_i,
  output list_stat_t stat_o
);

  entry_t             ent_w [DEPTH];
  logic [DEPTH-1:0]   valid_w;
  logic [DEPTH-1:0]   shift_w;
  entry_t             left_w [DEPTH];
  logic [DEPTH-1:0]   left_valid_w;
  entry_t             right_w [DEPTH];
  logic [DEPTH-1:0]   right_valid_w;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i]       = '0;
      assign left_valid_w[i] = 1'b0;
      assign shift_w[i]      = 1'b0;
    end else begin : g_mid
      assign left_w[i]       = ent_w[i-1];
      assign left_valid_w[i] = valid_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w[i]       = '0;
      assign right_valid_w[i] = 1'b0;
    end else begin : g_inner
      assign right_w[i]       = ent_w[i+1];
      assign right_valid_w[i] = valid_w[i+1];
    end

    if (i == DEPTH - 1) begin : g_tail
      dsdlb_cell u_cell (
        .clk_i,
        .rst_ni,
        .head_i        (1'b0),
        .ctrl_i,
        .left_i        (left_w[i]),
        .left_valid_i  (left_valid_w[i]),
        .right_i       (right_w[i]),
        .right_valid_i (right_valid_w[i]),
        .shift_i       (shift_w[i]),
        .shift_o       (),
        .ent_o         (ent_w[i]),
        .valid_o       (valid_w[i])
      );
    end else begin : g_body
      dsdlb_cell u_cell (
        .clk_i,
        .rst_ni,
        .head_i        (i == 0),
        .ctrl_i,
        .left_i        (left_w[i]),
        .left_valid_i  (left_valid_w[i]),
        .right_i       (right_w[i]),
        .right_valid_i (right_valid_w[i]),
        .shift_i       (shift_w[i]),
        .shift_o       (shift_w[i+1]),
        .ent_o         (ent_w[i]),
        .valid_o       (valid_w[i])
      );
    end
  end

  assign stat_o.head_valid = valid_w[0];
  assign stat_o.head       = ent_w[0];
  assign stat_o.next_valid = valid_w[1];
  assign stat_o.next_tex   = ent_w[1].tex;
  assign stat_o.full       = valid_w[DEPTH-1];

  // occupied cells always form a prefix of the row
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_w[DEPTH-1:1] & ~valid_w[DEPTH-2:0]) == '0)
    else $error("list occupancy has a gap");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.cmd == CMD_INS && !valid_w[DEPTH-1]
    |=> $countones(valid_w) == $past($countones(valid_w)) + 1)
    else $error("insert did not add exactly one entry");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.cmd == CMD_POP && valid_w[0]
    |=> $countones(valid_w) + 1 == $past($countones(valid_w)))
    else $error("pop did not remove exactly one entry");

  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.cmd == CMD_HOLD || ctrl_i.cmd == CMD_CMP |=> $stable(valid_w))
    else $error("list occupancy changed without insert or pop");

endmodule

// ===== hw/rtl/depth_sorted_draw_list_batcher_unit.sv =====
// Top level: two systolic draw lists, insert/flush sequencer and output register.
// Insert: compare, then shift-in with result load once output is free; no new beat until it is done.
// Flush: one result beat per cycle while out_free, one per entry, transparent list first; empty gives 1.
// Output register lets the next beat be accepted while a result waits downstream.
// Reset (async, active low) empties both lists and idles the sequencer; no clearing pass.
`timescale 1ns / 1ps
module depth_sorted_draw_list_batcher_unit
  import dsdlb_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // depth[15:0], texture_id[23:16], vertex_count[39:24], vertex_handle[55:40],
  // is_transparent[56], zero[63:57]
  input  logic [63:0] s_axis_tdata,
  // func[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], out_handle[17:2], out_count[33:18], out_texture[41:34],
  // out_transparent[42], vertex_offset[64:43], run_end[65], run_length[87:66]
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  typedef struct packed {
    logic [6:0]          pad;
    logic                is_transparent;
    logic [HANDLE_W-1:0] vertex_handle;
    logic [COUNT_W-1:0]  vertex_count;
    logic [TEX_W-1:0]    texture_id;
    logic [DEPTH_W-1:0]  depth;
  } in_beat_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] run_length;
    logic                run_end;
    logic [OFFSET_W-1:0] vertex_offset;
    logic                out_transparent;
    logic [TEX_W-1:0]    out_texture;
    logic [COUNT_W-1:0]  out_count;
    logic [HANDLE_W-1:0] out_handle;
    logic [STATUS_W-1:0] status;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_INS   = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  in_beat_t            in_w, item_q;
  logic [OFFSET_W-1:0] offset_q, offset_d;
  logic [OFFSET_W-1:0] run_q, run_d;
  logic                m_valid_q, m_valid_d;
  out_beat_t           m_data_q, m_data_d;
  logic                m_last_q, m_last_d;
  logic                load;
  logic                accept;
  logic                out_free;
  list_ctrl_t          ctrl_t, ctrl_o;
  list_stat_t          stat_t, stat_o;
  list_stat_t          cur;
  logic                from_t;
  logic                sel_full;
  logic                rend;
  logic [OFFSET_W-1:0] run_sum;
  logic [OFFSET_W-1:0] cnt_ext;
  entry_t              item_ent;

  assign in_w          = in_beat_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign item_ent.depth  = item_q.depth;
  assign item_ent.tex    = item_q.texture_id;
  assign item_ent.count  = item_q.vertex_count;
  assign item_ent.handle = item_q.vertex_handle;

  assign from_t   = stat_t.head_valid;
  assign cur      = from_t ? stat_t : stat_o;
  assign sel_full = item_q.is_transparent ? stat_t.full : stat_o.full;
  assign cnt_ext  = OFFSET_W'(cur.head.count);
  assign run_sum  = run_q + cnt_ext;
  assign rend     = !cur.next_valid || (cur.next_tex != cur.head.tex);

  always_comb begin
    state_d     = state_q;
    offset_d    = offset_q;
    run_d       = run_q;
    load        = 1'b0;
    m_data_d    = '0;
    m_last_d    = 1'b1;
    ctrl_t.cmd  = CMD_HOLD;
    ctrl_t.item = item_ent;
    ctrl_o.cmd  = CMD_HOLD;
    ctrl_o.item = item_ent;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          offset_d = '0;
          run_d    = '0;
          state_d  = (s_axis_tuser == FUNC_FLUSH) ? S_FLUSH : S_CMP;
        end
      end
      S_CMP: begin
        if (item_q.is_transparent) begin
          ctrl_t.cmd = CMD_CMP;
        end else begin
          ctrl_o.cmd = CMD_CMP;
        end
        state_d = S_INS;
      end
      S_INS: begin
        if (out_free) begin
          load            = 1'b1;
          m_data_d.status = sel_full ? ST_DROPPED : ST_INSERTED;
          if (!sel_full) begin
            if (item_q.is_transparent) begin
              ctrl_t.cmd = CMD_INS;
            end else begin
              ctrl_o.cmd = CMD_INS;
            end
          end
          state_d = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          load = 1'b1;
          if (cur.head_valid) begin
            m_data_d.status          = ST_FLUSHED;
            m_data_d.out_handle      = cur.head.handle;
            m_data_d.out_count       = cur.head.count;
            m_data_d.out_texture     = cur.head.tex;
            m_data_d.out_transparent = from_t;
            m_data_d.vertex_offset   = offset_q;
            m_data_d.run_end         = rend;
            m_data_d.run_length      = rend ? run_sum : '0;
            offset_d                 = offset_q + cnt_ext;
            run_d                    = rend ? '0 : run_sum;
            if (from_t) begin
              ctrl_t.cmd = CMD_POP;
              m_last_d   = !stat_t.next_valid && !stat_o.head_valid;
            end else begin
              ctrl_o.cmd = CMD_POP;
              m_last_d   = !stat_o.next_valid;
            end
          end else begin
            m_data_d.status = ST_EMPTY;
          end
          if (m_last_d) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    offset_q <= offset_d;
    run_q    <= run_d;
    if (accept) begin
      item_q <= in_w;
    end
    if (load) begin
      m_data_q <= m_data_d;
      m_last_q <= m_last_d;
    end
  end

  dsdlb_list #(
    .DEPTH (LIST_DEPTH)
  ) u_list_t (
    .clk_i,
    .rst_ni,
    .ctrl_i (ctrl_t),
    .stat_o (stat_t)
  );

  dsdlb_list #(
    .DEPTH (LIST_DEPTH)
  ) u_list_o (
    .clk_i,
    .rst_ni,
    .ctrl_i (ctrl_o),
    .stat_o (stat_o)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule
